// ----- rtl/tcpa_pkg.sv -----
package tcpa_pkg;

  // Field widths of the item formats, fixed by the interface.
  localparam int SIDE_W  = 14;
  localparam int PERIM_W = 16;
  localparam int AREA_W  = 29;

  // Default number of side bits that take part in the math.
  localparam int DEF_SIDE_WIDTH = 14;

  typedef struct packed {
    logic [SIDE_W-1:0] len_a;
    logic [SIDE_W-1:0] len_b;
    logic [SIDE_W-1:0] len_c;
  } in_item_t;

  typedef struct packed {
    logic               is_valid;
    logic [PERIM_W-1:0] perim;
    logic [AREA_W-1:0]  area_quarters;
  } out_item_t;

endpackage

// ----- rtl/triangle_check_perimeter_area_unit.sv -----
// Triangle check, perimeter and Heron area, one item per clock unless stalled.
// Each input item carries three unsigned side lengths. Only the low SIDE_WIDTH
// bits of each side are used. The matching result item gives is_valid, which
// is set when every pair of sides sums to strictly more than the third side,
// so degenerate and zero-length cases are rejected. It also gives perim, the
// sum of the sides, which is present even for a rejected item. The third field
// is area_quarters, floor(sqrt(P*(P-2a)*(P-2b)*(P-2c))). That value is four
// times the Heron area rounded down, and it is 0 for a rejected item. The block
// holds no state between items. It is a pipeline that takes a new item in every
// cycle in which in_stall is low. There are four front stages: the sums and the
// triangle test, the three factors, two parallel products, and the final
// product. After them comes one square-root stage per result bit, and last the
// output register. Each stage carries its own valid bit. A stage that is empty
// keeps loading while the output is stalled, so bubbles are squeezed out.
// in_stall rises only when every stage holds an item and the output item is
// not being taken.
module triangle_check_perimeter_area_unit #(
  parameter int SIDE_WIDTH = tcpa_pkg::DEF_SIDE_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tcpa_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tcpa_pkg::out_item_t  out_data
);
  import tcpa_pkg::*;

  // Widths follow from the side width. The perimeter and the factors need
  // two more bits, the four-way product needs four times that, and the root
  // needs half of the product.
  localparam int W    = SIDE_WIDTH;
  localparam int PW   = W + 2;
  localparam int MW   = 2 * PW;
  localparam int NW   = 4 * PW;
  localparam int RW   = 2 * PW;
  localparam int REMW = RW + 2;
  localparam int NS   = 4 + RW;

  // Valid bits for every stage. Stages 0 to 3 are the front end and the
  // rest are the square-root stages. en[k] loads stage k.
  logic [NS-1:0] v_r;
  logic [NS-1:0] en;
  logic          adv_out;

  assign adv_out = !out_valid || !out_stall;

  always_comb begin
    en[NS-1] = !v_r[NS-1] || adv_out;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_stall = !en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= (k == 0) ? in_valid : v_r[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  // Stage 1: mask the sides, form the perimeter and apply the triangle test.
  logic [W-1:0]  a1_r, b1_r, c1_r;
  logic [PW-1:0] p1_r;
  logic          ok1_r;
  logic [W-1:0]  a_in, b_in, c_in;
  logic [W:0]    sab, sac, sbc;

  assign a_in = in_data.len_a[W-1:0];
  assign b_in = in_data.len_b[W-1:0];
  assign c_in = in_data.len_c[W-1:0];
  assign sab  = {1'b0, a_in} + {1'b0, b_in};
  assign sac  = {1'b0, a_in} + {1'b0, c_in};
  assign sbc  = {1'b0, b_in} + {1'b0, c_in};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a1_r  <= a_in;
      b1_r  <= b_in;
      c1_r  <= c_in;
      p1_r  <= {1'b0, sab} + PW'(c_in);
      ok1_r <= (sab > {1'b0, c_in}) && (sac > {1'b0, b_in}) && (sbc > {1'b0, a_in});
    end
  end

  // Stage 2: the three factors P-2x. For a rejected item they are forced to
  // zero, so the product and the root come out as zero on their own.
  logic [PW-1:0] p2_r, da2_r, db2_r, dc2_r;
  logic          ok2_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      p2_r  <= p1_r;
      ok2_r <= ok1_r;
      da2_r <= ok1_r ? p1_r - {1'b0, a1_r, 1'b0} : '0;
      db2_r <= ok1_r ? p1_r - {1'b0, b1_r, 1'b0} : '0;
      dc2_r <= ok1_r ? p1_r - {1'b0, c1_r, 1'b0} : '0;
    end
  end

  // Stage 3: two products side by side.
  logic [PW-1:0] p3_r;
  logic          ok3_r;
  logic [MW-1:0] m13_r, m23_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      p3_r  <= p2_r;
      ok3_r <= ok2_r;
      m13_r <= MW'(p2_r) * MW'(da2_r);
      m23_r <= MW'(db2_r) * MW'(dc2_r);
    end
  end

  // Stage 4: the full radicand.
  logic [PW-1:0] p4_r;
  logic          ok4_r;
  logic [NW-1:0] prod4_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      p4_r    <= p3_r;
      ok4_r   <= ok3_r;
      prod4_r <= NW'(m13_r) * NW'(m23_r);
    end
  end

  // Square root, one result bit per stage. Each stage brings down the next
  // two radicand bits and tries to subtract the value 4*root+1.
  logic [REMW-1:0] rem_r  [RW];
  logic [RW-1:0]   root_r [RW];
  logic [NW-1:0]   rad_r  [RW];
  logic [PW-1:0]   sp_r   [RW];
  logic            sok_r  [RW];

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    logic [REMW-1:0] rem_in;
    logic [RW-1:0]   root_in;
    logic [NW-1:0]   rad_in;
    logic [PW-1:0]   p_in;
    logic            ok_in;
    logic [REMW-1:0] cand;
    logic [REMW-1:0] trial;
    logic            take;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = prod4_r;
      assign p_in    = p4_r;
      assign ok_in   = ok4_r;
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
      assign rad_in  = rad_r[j-1];
      assign p_in    = sp_r[j-1];
      assign ok_in   = sok_r[j-1];
    end

    assign cand  = {rem_in[REMW-3:0], rad_in[NW-1:NW-2]};
    assign trial = {root_in, 2'b01};
    assign take  = cand >= trial;

    always_ff @(posedge clk) begin
      if (en[4+j]) begin
        rem_r[j]  <= take ? cand - trial : cand;
        root_r[j] <= {root_in[RW-2:0], take};
        rad_r[j]  <= {rad_in[NW-3:0], 2'b00};
        sp_r[j]   <= p_in;
        sok_r[j]  <= ok_in;
      end
    end
  end

  // Output register. It holds a finished item while the far side stalls.
  logic      out_valid_r;
  out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_out) begin
      out_valid_r <= v_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      out_data_r.is_valid      <= sok_r[RW-1];
      out_data_r.perim         <= PERIM_W'(sp_r[RW-1]);
      out_data_r.area_quarters <= AREA_W'(root_r[RW-1]);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A rejected triangle never carries area.
  a_reject_zero_area: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_valid |-> out_data.area_quarters == '0)
    else $error("rejected item carries nonzero area");

  // A proper triangle has positive sides, so its perimeter is never zero.
  a_valid_perim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_valid |-> out_data.perim != '0)
    else $error("proper triangle with zero perimeter");

  // The last root stage leaves a remainder of at most twice the root.
  a_root_rem: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NS-1] |-> rem_r[RW-1] <= {root_r[RW-1], 1'b0})
    else $error("square root remainder out of range");

  // With the output free, the pipeline always takes a new item.
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

  // An accepted item always lands in the first stage.
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> v_r[0])
    else $error("accepted item lost at pipeline entry");

endmodule

// ----- bench/triangle_check_perimeter_area_unit_tb.sv -----
`timescale 1ns / 1ps

// Keeps the results that the pipeline still owes, in the order their side sets
// were accepted, and compares every returned item against the oldest one.
class triangle_scoreboard;
  localparam int SIDE_BITS = tcpa_pkg::DEF_SIDE_WIDTH;

  tcpa_pkg::out_item_t owed_results[$];
  int fault_count;
  int shown_count;

  function new();
    fault_count = 0;
    shown_count = 0;
  endfunction

  // Integer square root, rounded down, found one result bit at a time.
  function longint unsigned floor_root(longint unsigned value);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= value) begin
        root = trial;
      end
    end
    return root;
  endfunction

  // Triangle test, perimeter and four times the Heron area for one side set.
  function tcpa_pkg::out_item_t heron_result(tcpa_pkg::in_item_t sides);
    longint unsigned side_mask;
    longint unsigned a;
    longint unsigned b;
    longint unsigned c;
    longint unsigned p;
    longint unsigned prod;
    tcpa_pkg::out_item_t res;
    side_mask = (64'd1 << SIDE_BITS) - 1;
    a = longint'(sides.len_a) & side_mask;
    b = longint'(sides.len_b) & side_mask;
    c = longint'(sides.len_c) & side_mask;
    p = a + b + c;
    res = '0;
    res.perim = p[tcpa_pkg::PERIM_W-1:0];
    res.is_valid = (a + b > c) && (a + c > b) && (b + c > a);
    if (res.is_valid) begin
      prod = p * (p - 2 * a) * (p - 2 * b) * (p - 2 * c);
      prod = floor_root(prod);
      res.area_quarters = prod[tcpa_pkg::AREA_W-1:0];
    end
    return res;
  endfunction

  function void note_side_set(tcpa_pkg::in_item_t sides);
    owed_results.insert(owed_results.size(), heron_result(sides));
  endfunction

  function void check_result(tcpa_pkg::out_item_t got);
    tcpa_pkg::out_item_t want;
    if (owed_results.size() == 0) begin
      fault_count++;
      if (shown_count < 10) begin
        shown_count++;
        $display("%0t: result with nothing owed: valid=%0d perim=%0d area=%0d",
                 $time, got.is_valid, got.perim, got.area_quarters);
      end
      return;
    end
    want = owed_results.pop_front();
    if (got.is_valid !== want.is_valid || got.perim !== want.perim ||
        got.area_quarters !== want.area_quarters) begin
      fault_count++;
      if (shown_count < 10) begin
        shown_count++;
        $display("%0t: expected valid=%0d perim=%0d area=%0d, got valid=%0d perim=%0d area=%0d",
                 $time, want.is_valid, want.perim, want.area_quarters,
                 got.is_valid, got.perim, got.area_quarters);
      end
    end
  endfunction

  function int pending();
    return owed_results.size();
  endfunction

  function void flag_leftovers();
    if (owed_results.size() != 0) begin
      fault_count += owed_results.size();
      $display("%0d owed results never came out", owed_results.size());
    end
  endfunction
endclass

module triangle_check_perimeter_area_unit_tb;
  import tcpa_pkg::*;

  localparam int SIDE_MAX = (1 << SIDE_W) - 1;
  // The pipeline is 37 stages deep at the default width; the drain wait at the
  // end gives it well over that before leftovers are counted.
  localparam int DRAIN_CYCLES = 80;
  // Length of the long receiver hold-off, in cycles.
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 255;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  triangle_scoreboard sb;

  // Knobs set by the sequence and read by the two driving processes.
  bit source_jitter;
  bit sink_jitter;
  bit hold_request;

  triangle_check_perimeter_area_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop. The slowest correct run, with every item hit by the longest
  // source gap and sink stall, stays several times below this.
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Idle lengths for both sides: mostly none or short, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end else if (roll < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 80);
  endfunction

  // Puts three side values into the item fields in a random order, so that
  // every field gets to be the long side, the short side and so on.
  function automatic in_item_t arrange_sides(int x, int y, int z);
    in_item_t item;
    logic [SIDE_W-1:0] sx;
    logic [SIDE_W-1:0] sy;
    logic [SIDE_W-1:0] sz;
    sx = SIDE_W'(x);
    sy = SIDE_W'(y);
    sz = SIDE_W'(z);
    case ($urandom_range(0, 5))
      0: item = '{len_a: sx, len_b: sy, len_c: sz};
      1: item = '{len_a: sx, len_b: sz, len_c: sy};
      2: item = '{len_a: sy, len_b: sx, len_c: sz};
      3: item = '{len_a: sy, len_b: sz, len_c: sx};
      4: item = '{len_a: sz, len_b: sx, len_c: sy};
      default: item = '{len_a: sz, len_b: sy, len_c: sx};
    endcase
    return item;
  endfunction

  // Random side sets. Uniform values reject about half the time, so a good
  // share is built to be a proper triangle, some use tiny sides, and some sit
  // right at the degenerate boundary where a pair sum equals the third side.
  function automatic in_item_t random_sides();
    int roll;
    int x;
    int y;
    int z;
    int lo;
    int hi;
    roll = $urandom_range(0, 99);
    x = $urandom_range(0, SIDE_MAX);
    y = $urandom_range(0, SIDE_MAX);
    z = $urandom_range(0, SIDE_MAX);
    if (roll < 35) begin
      return arrange_sides(x, y, z);
    end else if (roll < 75) begin
      x = $urandom_range(1, SIDE_MAX);
      y = $urandom_range(1, SIDE_MAX);
      lo = (x > y ? x - y : y - x) + 1;
      hi = (x + y - 1 > SIDE_MAX) ? SIDE_MAX : x + y - 1;
      z = $urandom_range(hi, lo);
    end else if (roll < 85) begin
      x = $urandom_range(0, 15);
      y = $urandom_range(0, 15);
      z = $urandom_range(0, 15);
    end else begin
      case ($urandom_range(0, 3))
        0: z = x + y;
        1: z = x + y - 1;
        2: z = x > y ? x - y : y - x;
        default: z = (x > y ? x - y : y - x) + 1;
      endcase
      if (z > SIDE_MAX) begin
        z = SIDE_MAX;
      end
      if (z < 0) begin
        z = 0;
      end
    end
    return arrange_sides(x, y, z);
  endfunction

  // Offers one item and holds it until the block takes it. The item is logged
  // at the edge where valid is high and stall is low.
  task automatic send_sides(in_item_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    do begin
      @(posedge clk);
    end while (in_stall);
    sb.note_side_set(item);
  endtask

  // Optional source gap after an accepted item. With no gap, valid simply
  // stays high for the next item.
  task automatic source_rest();
    int gap;
    gap = source_jitter ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_directed(int x, int y, int z);
    send_sides('{len_a: SIDE_W'(x), len_b: SIDE_W'(y), len_c: SIDE_W'(z)});
    source_rest();
  endtask

  // Result side. Outputs are looked at right after the edge, so the values
  // seen are the ones the handshake used. The stall for the next edge is
  // chosen afterwards: a long hold-off once when asked for, random runs when
  // jitter is on, otherwise always ready.
  initial begin : result_sink
    int stall_run;
    int hold_left;
    bit stall_next;
    bit hold_taken;
    stall_run = 0;
    hold_left = 0;
    hold_taken = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && !out_stall) begin
        sb.check_result(out_data);
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (hold_request && !hold_taken) begin
        hold_left = HOLD_CYCLES;
        hold_taken = 1'b1;
        stall_next = 1'b1;
      end else if (stall_run > 0) begin
        stall_run--;
        stall_next = 1'b1;
      end else if (sink_jitter && $urandom_range(0, 99) < 25) begin
        stall_run = pick_gap();
        stall_next = 1'b1;
      end else begin
        stall_next = 1'b0;
      end
      out_stall <= stall_next;
    end
  end

  initial begin : side_source
    sb = new();
    source_jitter = 1'b0;
    sink_jitter = 1'b0;
    hold_request = 1'b0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: the field extremes, each way a side set can fail the
    // strict triangle test, the degenerate boundary on each side, and a few
    // known areas such as the 3-4-5 right triangle.
    source_jitter = 1'b1;
    sink_jitter = 1'b1;
    send_directed(0, 0, 0);
    send_directed(SIDE_MAX, SIDE_MAX, SIDE_MAX);
    send_directed(1, 1, 1);
    send_directed(3, 4, 5);
    send_directed(1, 2, 3);
    send_directed(3, 1, 2);
    send_directed(2, 3, 1);
    send_directed(0, 5, 5);
    send_directed(5, 0, 5);
    send_directed(5, 5, 0);
    send_directed(10, 3, 3);
    send_directed(3, 10, 3);
    send_directed(3, 3, 10);
    send_directed(SIDE_MAX, SIDE_MAX, 1);
    send_directed(SIDE_MAX, 1, 1);
    send_directed(SIDE_MAX, SIDE_MAX, 0);
    send_directed(8191, 8192, SIDE_MAX);
    send_directed(8192, 8192, SIDE_MAX);
    send_directed(14'h2AAA, 14'h2AAA, 14'h1555);
    send_directed(14'h1555, 14'h1555, 14'h2AAA);

    // Random part in phases with different pacing on each side.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          source_jitter = 1'b1;
          sink_jitter = 1'b1;
        end
        1: begin
          // Full rate both ways.
          source_jitter = 1'b0;
          sink_jitter = 1'b0;
        end
        2: begin
          source_jitter = 1'b0;
          sink_jitter = 1'b1;
        end
        3: begin
          // The source first waits for the pipeline to empty completely.
          in_valid <= 1'b0;
          while (sb.pending() != 0) @(posedge clk);
          source_jitter = 1'b1;
          sink_jitter = 1'b0;
        end
        4: begin
          // The sink holds off for a long stretch while items keep coming,
          // so every stage fills and the block stalls its input.
          source_jitter = 1'b0;
          sink_jitter = 1'b0;
          hold_request = 1'b1;
        end
        default: begin
          source_jitter = 1'b1;
          sink_jitter = 1'b1;
        end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_sides(random_sides());
        source_rest();
      end
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.flag_leftovers();
    if (sb.fault_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
